// ===== rtl/tfe_pkg.sv =====
package tfe_pkg;

    localparam int WORDS_PER_FRAME = 23;
    localparam int POS_W = 6;

    localparam logic [7:0] SYNC_A = 8'h7F;
    localparam logic [7:0] SYNC_B = 8'hFE;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // byte sequencer steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_SYNC0 = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SYNC1 = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SYNC2 = 3'd2;
    localparam logic [STEP_W-1:0] STEP_HI    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LO    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_CHK   = 3'd5;

    typedef struct packed {
        logic signed [15:0] channel_word;
        logic               first;
        logic               last;
    } tfe_req_t;

endpackage

// ===== rtl/tfe_if.sv =====
interface tfe_word_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] channel_word;

    modport source (output valid, output channel_word, input ready);
    modport sink (input valid, input channel_word, output ready);
endinterface

interface tfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_frame;

    modport source (output valid, output out_byte, output end_of_run, output end_of_frame,
                    input ready);
    modport sink (input valid, input out_byte, input end_of_run, input end_of_frame,
                  output ready);
endinterface

// ===== rtl/tfe_front.sv =====
module tfe_front (
    input  logic              clk,
    input  logic              rst_n,
    tfe_word_if.sink          samples,
    input  logic              q_full,
    output logic              push,
    output tfe_pkg::tfe_req_t push_req
);

    logic [tfe_pkg::POS_W-1:0] pos_reg;
    logic [tfe_pkg::POS_W-1:0] pos_next;
    logic [tfe_pkg::POS_W:0]   pos_inc;
    logic                      last;

    assign samples.ready = !q_full;
    assign push          = samples.valid && samples.ready;

    assign pos_inc = {1'b0, pos_reg} + (tfe_pkg::POS_W+1)'(1);
    // counter reached the limit closes the frame
    assign last    = pos_inc >= (tfe_pkg::POS_W+1)'(tfe_pkg::WORDS_PER_FRAME);

    assign push_req.channel_word = samples.channel_word;
    assign push_req.first        = (pos_reg == '0);
    assign push_req.last         = last;

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            pos_next = last ? '0 : pos_inc[tfe_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < tfe_pkg::POS_W'(tfe_pkg::WORDS_PER_FRAME))
        else $error("word position past frame length");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("request pushed into full queue");

    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && last) |=> pos_reg == '0)
        else $error("position did not wrap after frame close");

endmodule

// ===== rtl/tfe_queue.sv =====
module tfe_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tfe_pkg::tfe_req_t push_req,
    input  logic              pop,
    output tfe_pkg::tfe_req_t head,
    output logic              q_full,
    output logic              q_valid
);

    tfe_pkg::tfe_req_t           mem [tfe_pkg::Q_DEPTH];
    logic [tfe_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [tfe_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [tfe_pkg::Q_CNT_W-1:0] count_reg;
    logic [tfe_pkg::Q_CNT_W-1:0] count_next;

    assign q_full  = (count_reg == tfe_pkg::Q_CNT_W'(tfe_pkg::Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + tfe_pkg::Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - tfe_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + tfe_pkg::Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + tfe_pkg::Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tfe_pkg::Q_CNT_W'(tfe_pkg::Q_DEPTH))
        else $error("queue count overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || q_full) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step with count");

endmodule

// ===== rtl/tfe_back.sv =====
module tfe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  tfe_pkg::tfe_req_t head,
    input  logic              q_valid,
    output logic              pop,
    tfe_byte_if.source        frame
);

    logic                           busy_reg;
    logic                           busy_next;
    logic [tfe_pkg::STEP_W-1:0]     step_reg;
    logic [tfe_pkg::STEP_W-1:0]     step_next;
    logic [tfe_pkg::STEP_W-1:0]     step;
    tfe_pkg::tfe_req_t              cur_reg;
    tfe_pkg::tfe_req_t              cur;
    logic [7:0]                     sum_reg;
    logic [7:0]                     sum_next;
    logic [7:0]                     byte_val;
    logic                           done;
    logic                           out_free;
    logic                           emit;

    logic                           ovalid_reg;
    logic [7:0]                     obyte_reg;
    logic                           oeor_reg;
    logic                           oeof_reg;

    assign out_free = !ovalid_reg || frame.ready;
    // an idle sequencer works straight off the queue head
    assign cur      = busy_reg ? cur_reg : head;
    assign step     = busy_reg ? step_reg
                    : (head.first ? tfe_pkg::STEP_SYNC0 : tfe_pkg::STEP_HI);
    assign emit     = out_free && (busy_reg || q_valid);
    assign pop      = emit && !busy_reg;

    always_comb
    begin
        byte_val  = 8'h00;
        step_next = step;
        done      = 1'b0;
        sum_next  = sum_reg;
        unique case (step)
            tfe_pkg::STEP_SYNC0:
            begin
                byte_val  = tfe_pkg::SYNC_A;
                step_next = tfe_pkg::STEP_SYNC1;
            end
            tfe_pkg::STEP_SYNC1:
            begin
                byte_val  = tfe_pkg::SYNC_A;
                step_next = tfe_pkg::STEP_SYNC2;
            end
            tfe_pkg::STEP_SYNC2:
            begin
                byte_val  = tfe_pkg::SYNC_B;
                step_next = tfe_pkg::STEP_HI;
            end
            tfe_pkg::STEP_HI:
            begin
                byte_val  = cur.channel_word[15:8];
                step_next = tfe_pkg::STEP_LO;
            end
            tfe_pkg::STEP_LO:
            begin
                byte_val  = cur.channel_word[7:0];
                step_next = tfe_pkg::STEP_CHK;
                done      = !cur.last;
            end
            tfe_pkg::STEP_CHK:
            begin
                byte_val  = sum_reg;
                step_next = tfe_pkg::STEP_SYNC0;
                done      = 1'b1;
            end
            default:
            begin
                byte_val  = 8'h00;
                step_next = tfe_pkg::STEP_SYNC0;
                done      = 1'b1;
            end
        endcase
        if (step == tfe_pkg::STEP_SYNC0)
        begin
            sum_next = byte_val;
        end
        else if (step == tfe_pkg::STEP_CHK)
        begin
            sum_next = 8'h00;
        end
        else
        begin
            sum_next = sum_reg + byte_val;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (emit)
        begin
            busy_next = !done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (emit)
        begin
            obyte_reg <= byte_val;
            oeor_reg  <= done;
            oeof_reg  <= (step == tfe_pkg::STEP_CHK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= tfe_pkg::STEP_SYNC0;
            sum_reg    <= 8'h00;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (emit)
            begin
                step_reg <= step_next;
                sum_reg  <= sum_next;
            end
            if (out_free)
            begin
                ovalid_reg <= emit;
            end
        end
    end

    assign frame.valid        = ovalid_reg;
    assign frame.out_byte     = obyte_reg;
    assign frame.end_of_run   = oeor_reg;
    assign frame.end_of_frame = oeof_reg;

    a_eof_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && oeof_reg) |-> oeor_reg)
        else $error("frame close without end of run");

    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && step == tfe_pkg::STEP_CHK) |=> sum_reg == 8'h00)
        else $error("checksum not cleared after frame close");

    a_chk_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && step == tfe_pkg::STEP_CHK) |-> cur.last)
        else $error("checksum emitted mid frame");

endmodule

// ===== rtl/telemetry_frame_encoder.sv =====
// channel   dir   handshake      payload
// samples   in    valid/ready    channel_word (s16)
// frame     out   valid/ready    out_byte (u8), end_of_run, end_of_frame
//
// one byte per cycle leaves the output register while frame is ready; a
// word gives 2 to 5 bytes: 5 at the start of a frame, 3 at its end, 2 otherwise
// the byte sequencer in the back end sets that pace; a two-entry queue lets
// the front accept the next request while the back is still serializing
// rst_n clears the word counter, running sum, queue and output valid
// a stall on frame holds the output byte; samples stalls only on a full queue
module telemetry_frame_encoder (
    input  logic       clk,
    input  logic       rst_n,
    tfe_word_if.sink   samples,
    tfe_byte_if.source frame
);

    tfe_pkg::tfe_req_t push_req;
    tfe_pkg::tfe_req_t head;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_valid;

    tfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .q_full   (q_full),
        .push     (push),
        .push_req (push_req)
    );

    tfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .q_full   (q_full),
        .q_valid  (q_valid)
    );

    tfe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_valid (q_valid),
        .pop     (pop),
        .frame   (frame)
    );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int DIRECTED_N    = 14;
    localparam int RANDOM_N      = 270;
    localparam int QUIET_TAIL    = 40;
    localparam int PRESSURE_AT   = 120;
    localparam int PRESSURE_RUN  = 24;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [7:0] octet;
        logic       run_end;
        logic       frame_end;
    } frame_octet_t;

    class frame_scoreboard;
        logic [tfe_pkg::POS_W-1:0] word_pos;
        logic [7:0]                frame_sum;
        frame_octet_t              expected_octets[$];
        int                        errors;

        function new();
            word_pos  = '0;
            frame_sum = '0;
            errors    = 0;
        endfunction

        // works out the bytes one accepted word must produce
        function void note_word(logic [15:0] w);
            frame_octet_t burst[6];
            int           n;
            int           i;
            n = 0;
            if (word_pos == '0) begin
                burst[0]  = '{tfe_pkg::SYNC_A, 1'b0, 1'b0};
                burst[1]  = '{tfe_pkg::SYNC_A, 1'b0, 1'b0};
                burst[2]  = '{tfe_pkg::SYNC_B, 1'b0, 1'b0};
                frame_sum = tfe_pkg::SYNC_A + tfe_pkg::SYNC_A + tfe_pkg::SYNC_B;
                n = 3;
            end
            burst[n]     = '{w[15:8], 1'b0, 1'b0};
            burst[n + 1] = '{w[7:0], 1'b0, 1'b0};
            frame_sum    = frame_sum + w[15:8] + w[7:0];
            n = n + 2;
            // counter at or past the limit closes the frame
            if (int'(word_pos) + 1 >= tfe_pkg::WORDS_PER_FRAME) begin
                burst[n] = '{frame_sum, 1'b0, 1'b1};
                n = n + 1;
                word_pos  = '0;
                frame_sum = '0;
            end else begin
                word_pos = word_pos + tfe_pkg::POS_W'(1);
            end
            burst[n - 1].run_end = 1'b1;
            for (i = 0; i < n; i++) begin
                expected_octets.push_back(burst[i]);
            end
        endfunction

        function void check_octet(logic [7:0] octet, logic run_end, logic frame_end);
            frame_octet_t exp_o;
            if (expected_octets.size() == 0) begin
                $error("unexpected byte %02h with nothing pending", octet);
                errors++;
                return;
            end
            exp_o = expected_octets.pop_front();
            if (octet !== exp_o.octet) begin
                $error("out_byte: expected %02h, got %02h", exp_o.octet, octet);
                errors++;
            end
            if (run_end !== exp_o.run_end) begin
                $error("end_of_run: expected %0b, got %0b", exp_o.run_end, run_end);
                errors++;
            end
            if (frame_end !== exp_o.frame_end) begin
                $error("end_of_frame: expected %0b, got %0b", exp_o.frame_end, frame_end);
                errors++;
            end
        endfunction

        function int pending();
            return expected_octets.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    bit   quiet_phase = 1'b0;
    bit   long_hold_req = 1'b0;

    frame_scoreboard sb = new();

    tfe_word_if samples ();
    tfe_byte_if frame ();

    telemetry_frame_encoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .frame   (frame.source)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && frame.valid && frame.ready)
            sb.check_octet(frame.out_byte, frame.end_of_run, frame.end_of_frame);
    end

    // output side: ready runs, short stalls, and one long hold-off on request
    initial
    begin
        frame.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                frame.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                frame.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                frame.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic [15:0] w, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            samples.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples.valid        <= 1'b1;
        samples.channel_word <= w;
        do
            @(posedge clk);
        while (!samples.ready);
        sb.note_word(w);
    endtask

    function automatic logic [15:0] random_word();
        logic [15:0] w;
        case ($urandom_range(0, 9))
            0: w = 16'h8000;
            1: w = 16'h7FFF;
            2: w = 16'hFFFF;
            3: w = 16'h0000;
            default: w = 16'($urandom);
        endcase
        return w;
    endfunction

    logic [15:0] directed_words[DIRECTED_N] = '{
        16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h00FF,
        16'hFF00, 16'hAAAA, 16'h5555, 16'h0080, 16'h8080, 16'h7F7F, 16'hFE7F
    };

    initial
    begin
        int  i;
        bit  may_idle;
        rst_n                 = 1'b0;
        samples.valid        <= 1'b0;
        samples.channel_word <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_N; i++)
            send_word(directed_words[i], 1'b1);

        for (i = 0; i < RANDOM_N; i++)
        begin
            if (i == PRESSURE_AT)
                long_hold_req = 1'b1;
            if (i == RANDOM_N - QUIET_TAIL)
                quiet_phase = 1'b1;
            // keep requests coming back to back while the output is held off and in the quiet tail
            may_idle = !quiet_phase && !(i >= PRESSURE_AT && i < PRESSURE_AT + PRESSURE_RUN);
            send_word(random_word(), may_idle);
        end
        samples.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
